[rtl/sipq_pkg.sv]
// Shared types and constants for the sorted-insert priority queue.
package sipq_pkg;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned KEY_WIDTH = 16;

  localparam int unsigned KEY_W = (KEY_WIDTH < 16) ? KEY_WIDTH : 16;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_POP    = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] item_value;
    logic [15:0] item_key;
  } in_beat_t;

  typedef struct packed {
    logic        head_valid;
    logic [31:0] head_value;
    logic [15:0] head_key;
    logic [31:0] popped_value;
    logic [1:0]  status;
    logic [4:0]  occupancy;
  } out_beat_t;

  typedef struct packed {
    logic [31:0]      value;
    logic [KEY_W-1:0] key;
  } entry_t;

  typedef struct packed {
    logic   push;
    logic   ordered;
    logic   pop;
    entry_t item;
  } ctrl_t;

endpackage

[rtl/sipq_cell.sv]
// One queue slot: holds an entry and shifts toward the head or tail.
module sipq_cell (
  input  logic           clk_i,
  input  sipq_pkg::ctrl_t ctrl_i,
  input  logic           occ_i,
  input  logic           found_i,
  input  sipq_pkg::entry_t left_i,
  input  sipq_pkg::entry_t right_i,
  output logic           found_o,
  output sipq_pkg::entry_t entry_d_o,
  output sipq_pkg::entry_t entry_q_o
);
  import sipq_pkg::*;

  entry_t entry_q, entry_d;
  logic   claim;

  assign claim   = ctrl_i.push && !found_i &&
                   (!occ_i || (ctrl_i.ordered && entry_q.key >= ctrl_i.item.key));
  assign found_o = found_i | claim;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.push) begin
      if (claim) begin
        entry_d = ctrl_i.item;
      end else if (found_i) begin
        entry_d = left_i;
      end
    end else if (ctrl_i.pop) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_d_o = entry_d;
  assign entry_q_o = entry_q;

endmodule

[rtl/sorted_insert_priority_queue.sv]
// Top level of the sorted-insert priority queue: cell row, count and result register.
// A bounded queue of DEPTH key/value entries held in a row of cells that shift as
// one. Each beat carries append, ordered insert or pop; every beat yields one
// result beat showing the head, any popped value, a status and the occupancy.
// The whole cell row updates in the cycle a beat is accepted and its result appears in
// the output register on the next cycle. A new beat is taken whenever the output
// register is empty or being drained, so back-to-back beats run at one per cycle
// while the consumer keeps up. Pop on an empty queue and push into a full queue are
// flagged in status and leave the queue unchanged.
module sorted_insert_priority_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sipq_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sipq_pkg::out_beat_t out_data_o
);
  import sipq_pkg::*;

  logic               in_fire;
  logic               is_push, is_pop, full, empty;
  logic [CNT_W-1:0]   count_q, count_d;
  ctrl_t              ctrl;
  logic [DEPTH-1:0]   occ;
  logic [DEPTH:0]     found;
  entry_t             cell_d [DEPTH];
  entry_t             cell_q [DEPTH];
  status_e            status;
  logic               out_valid_q;
  out_beat_t          out_q, out_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign full    = (count_q == CNT_W'(DEPTH));
  assign empty   = (count_q == '0);
  assign is_push = (in_data_i.command == CMD_APPEND) || (in_data_i.command == CMD_INSERT);
  assign is_pop  = (in_data_i.command == CMD_POP);

  always_comb begin
    ctrl.push       = in_fire && is_push && !full;
    ctrl.ordered    = (in_data_i.command == CMD_INSERT);
    ctrl.pop        = in_fire && is_pop && !empty;
    ctrl.item.value = in_data_i.item_value;
    ctrl.item.key   = in_data_i.item_key[KEY_W-1:0];
  end

  always_comb begin
    status = ST_OK;
    if (is_push && full) begin
      status = ST_FULL;
    end else if (is_pop && empty) begin
      status = ST_EMPTY;
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.push) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl.pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  assign found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left, right;
    assign occ[i] = (CNT_W'(i) < count_q);
    if (i == 0) begin : g_first
      assign left = ctrl.item;
    end else begin : g_mid
      assign left = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = cell_q[i];
    end else begin : g_body
      assign right = cell_q[i+1];
    end
    sipq_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .occ_i     (occ[i]),
      .found_i   (found[i]),
      .left_i    (left),
      .right_i   (right),
      .found_o   (found[i+1]),
      .entry_d_o (cell_d[i]),
      .entry_q_o (cell_q[i])
    );
  end

  always_comb begin
    out_d.head_valid   = (count_d != '0);
    out_d.head_value   = out_d.head_valid ? cell_d[0].value : 32'd0;
    out_d.head_key     = out_d.head_valid ? 16'(cell_d[0].key) : 16'd0;
    out_d.popped_value = ctrl.pop ? cell_q[0].value : 32'd0;
    out_d.status       = status;
    out_d.occupancy    = 5'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
